[hdl/tccw_pkg.sv]
// Shared types and constants for the text console cell writer.
// Request and response payload structs, operation and control codes.
// No dependencies.
`default_nettype none

package tccw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STEP = 8;

    // Field widths of the channels
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;
    localparam int OP_W   = 2;

    localparam logic [CHAR_W-1:0] COLOUR_RESET = 8'd7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
    localparam logic [OP_W-1:0] OP_SEEK = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_byte;
        logic [POS_W-1:0]  new_position;
        logic              end_of_write;
    } tccw_req_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_now;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
        logic              write_done;
    } tccw_rsp_t;

endpackage

`default_nettype wire

[hdl/text_console_cell_writer.sv]
// Text console cell writer: screen cell store, cursor and small sequencer.
// Depends on tccw_pkg for payload structs and codes.
//
// Usage:
//   s_valid/s_ready/s_req carry one request: put a character, set the
//   cursor or read a cell. m_valid/m_ready/m_rsp return exactly one
//   response per request, with the cursor after the request.
//   text_colour_we/text_colour_wdata set the attribute byte of written
//   cells; write it only while no request is in flight.
// Sequence from accept to response loaded:
//   put, newline, tab, backspace, unused code: the execute step only
//   read cell: execute, then one registered read of the cell memory
//   set cursor: execute, then the steps of the shared subtractor,
//     dividing the cell index by COLUMNS, then the column by TAB_STEP
//   scroll: after execute, one cell copied per cycle
//     through the single write port of the cell memory, then the
//     bottom row blanked one cell per cycle
//   s_ready rises in the same cycle as m_valid for the loaded response.
// Reset: a clearing pass writes every cell to zero, with s_ready low;
//   colour goes to 7 and the cursor to cell 0.
// Stall: a finished response waits in the output register; the next
//   request is taken and worked on meanwhile, and its response waits
//   until the register is free.
`default_nettype none

module text_console_cell_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS  = DEF_COLUMNS,
    parameter int ROWS     = DEF_ROWS,
    parameter int TAB_STEP = DEF_TAB_STEP
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tccw_req_t         s_req,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tccw_rsp_t              m_rsp,
    input  wire logic              text_colour_we,
    input  wire logic [CHAR_W-1:0] text_colour_wdata
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CW      = $clog2(CELLS);
    localparam int COLW    = $clog2(COLUMNS);
    localparam int ROWW    = $clog2(ROWS);
    localparam int PHW     = $clog2(TAB_STEP);
    localparam int TW      = ((COLW > PHW) ? COLW : PHW) + 1;
    localparam int LAST_PH = (COLUMNS - 1) % TAB_STEP;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_EXEC   = 4'd2;
    localparam logic [3:0] ST_RDWAIT = 4'd3;
    localparam logic [3:0] ST_SEEKR  = 4'd4;
    localparam logic [3:0] ST_SEEKT  = 4'd5;
    localparam logic [3:0] ST_COPY   = 4'd6;
    localparam logic [3:0] ST_BLANK  = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]        state_reg, state_next;
    tccw_req_t         req_reg, req_next;
    logic [CW-1:0]     cur_reg, cur_next;
    logic [COLW-1:0]   col_reg, col_next;
    logic [ROWW-1:0]   row_reg, row_next;
    logic [PHW-1:0]    phase_reg, phase_next;
    logic [CW-1:0]     work_reg, work_next;
    logic [CW-1:0]     wa_reg, wa_next;
    logic              pend_reg, pend_next;
    logic              scr_reg, scr_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [CHAR_W-1:0] colour_reg;
    logic              m_valid_reg, m_valid_next;
    tccw_rsp_t         m_rsp_reg, m_rsp_next;

    // cell memory, one write and one registered read port
    logic [CELL_W-1:0] mem [CELLS];
    logic              mem_we;
    logic [CW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [CW-1:0]     mem_raddr;
    logic [CELL_W-1:0] rdata_reg;

    logic [CW-1:0]     clamp_pos;
    logic [CW-1:0]     sub_op;
    logic              sub_ge;
    logic [CW-1:0]     sub_diff;
    logic [TW-1:0]     tab_adv;
    logic [TW-1:0]     tab_col;
    logic [CELL_W-1:0] blank;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;
    assign blank   = {colour_reg, {CHAR_W{1'b0}}};

    always_comb begin
        if (32'(req_reg.new_position) >= 32'(CELLS)) begin
            clamp_pos = CW'(CELLS - 1);
        end else begin
            clamp_pos = CW'(req_reg.new_position);
        end
    end

    // shared subtract/compare unit for the cursor divide steps
    assign sub_op   = (state_reg == ST_SEEKR) ? CW'(COLUMNS) : CW'(TAB_STEP);
    assign sub_ge   = (work_reg >= sub_op);
    assign sub_diff = work_reg - sub_op;

    assign tab_adv = TW'(TAB_STEP) - TW'(phase_reg);
    assign tab_col = TW'(col_reg) + tab_adv;

    assign mem_raddr = (state_reg == ST_EXEC) ? clamp_pos : work_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        cur_next     = cur_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        phase_next   = phase_reg;
        work_next    = work_reg;
        wa_next      = wa_reg;
        pend_next    = pend_reg;
        scr_next     = scr_reg;
        cell_next    = cell_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rsp_next   = m_rsp_reg;
        mem_we       = 1'b0;
        mem_waddr    = cur_reg;
        mem_wdata    = blank;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = work_reg;
                mem_wdata = '0;
                if (work_reg == CW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    work_next = work_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req;
                    scr_next   = 1'b0;
                    cell_next  = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                case (req_reg.operation)
                    OP_PUT: begin
                        // newline, tab past the row and a printable in the last
                        // column all end in the same line feed
                        logic do_lf;
                        do_lf = 1'b0;
                        if (req_reg.char_byte == CH_CR) begin
                            do_lf = 1'b0;
                        end else if (req_reg.char_byte == CH_LF) begin
                            do_lf = 1'b1;
                        end else if (req_reg.char_byte == CH_TAB) begin
                            if (32'(tab_col) >= 32'(COLUMNS)) begin
                                do_lf = 1'b1;
                            end else begin
                                cur_next   = cur_reg + CW'(tab_adv);
                                col_next   = COLW'(tab_col);
                                phase_next = '0;
                            end
                        end else if (req_reg.char_byte == CH_BS) begin
                            if (cur_reg != '0) begin
                                cur_next  = cur_reg - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = cur_reg - 1'b1;
                                mem_wdata = blank;
                                if (col_reg == '0) begin
                                    col_next   = COLW'(COLUMNS - 1);
                                    row_next   = row_reg - 1'b1;
                                    phase_next = PHW'(LAST_PH);
                                end else begin
                                    col_next   = col_reg - 1'b1;
                                    phase_next = (phase_reg == '0) ?
                                                 PHW'(TAB_STEP - 1) : phase_reg - 1'b1;
                                end
                            end
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_reg;
                            mem_wdata = {colour_reg, req_reg.char_byte};
                            if (col_reg == COLW'(COLUMNS - 1)) begin
                                do_lf = 1'b1;
                            end else begin
                                cur_next   = cur_reg + 1'b1;
                                col_next   = col_reg + 1'b1;
                                phase_next = (phase_reg == PHW'(TAB_STEP - 1)) ?
                                             '0 : phase_reg + 1'b1;
                            end
                        end
                        if (do_lf) begin
                            col_next   = '0;
                            phase_next = '0;
                            if (row_reg == ROWW'(ROWS - 1)) begin
                                cur_next   = CW'(CELLS - COLUMNS);
                                scr_next   = 1'b1;
                                work_next  = CW'(COLUMNS);
                                pend_next  = 1'b0;
                                state_next = ST_COPY;
                            end else begin
                                cur_next = cur_reg + CW'(COLUMNS) - CW'(col_reg);
                                row_next = row_reg + 1'b1;
                            end
                        end
                    end
                    OP_SEEK: begin
                        cur_next   = clamp_pos;
                        work_next  = clamp_pos;
                        row_next   = '0;
                        state_next = ST_SEEKR;
                    end
                    OP_READ: begin
                        state_next = ST_RDWAIT;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RDWAIT: begin
                cell_next  = rdata_reg;
                state_next = ST_DONE;
            end
            ST_SEEKR: begin
                if (sub_ge) begin
                    work_next = sub_diff;
                    row_next  = row_reg + 1'b1;
                end else begin
                    col_next   = COLW'(work_reg);
                    state_next = ST_SEEKT;
                end
            end
            ST_SEEKT: begin
                if (sub_ge) begin
                    work_next = sub_diff;
                end else begin
                    phase_next = PHW'(work_reg);
                    state_next = ST_DONE;
                end
            end
            ST_COPY: begin
                // read cell work_reg now, write it one row up next cycle
                mem_we    = pend_reg;
                mem_waddr = wa_reg;
                mem_wdata = rdata_reg;
                wa_next   = work_reg - CW'(COLUMNS);
                pend_next = 1'b1;
                if (work_reg == CW'(CELLS - 1)) begin
                    work_next  = CW'(CELLS - COLUMNS);
                    state_next = ST_BLANK;
                end else begin
                    work_next = work_reg + 1'b1;
                end
            end
            ST_BLANK: begin
                mem_we = 1'b1;
                if (pend_reg) begin
                    mem_waddr = wa_reg;
                    mem_wdata = rdata_reg;
                    pend_next = 1'b0;
                end else begin
                    mem_waddr = work_reg;
                    mem_wdata = blank;
                    if (work_reg == CW'(CELLS - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        work_next = work_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_rsp_next.cursor_now = POS_W'(cur_reg);
                    m_rsp_next.cell_data  = cell_reg;
                    m_rsp_next.scrolled   = scr_reg;
                    m_rsp_next.write_done = req_reg.end_of_write;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cur_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            work_reg    <= '0;
            pend_reg    <= 1'b0;
            scr_reg     <= 1'b0;
            colour_reg  <= COLOUR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            phase_reg   <= phase_next;
            work_reg    <= work_next;
            pend_reg    <= pend_next;
            scr_reg     <= scr_next;
            m_valid_reg <= m_valid_next;
            if (text_colour_we) begin
                colour_reg <= text_colour_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        wa_reg    <= wa_next;
        cell_reg  <= cell_next;
        m_rsp_reg <= m_rsp_next;
    end

    // cursor index, row and column agree whenever a request may enter
    a_cursor_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |->
            (32'(cur_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg)))
        else $error("cursor index does not match row and column");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |->
            (32'(cur_reg) < 32'(CELLS) && 32'(col_reg) < 32'(COLUMNS)
             && 32'(phase_reg) < 32'(TAB_STEP)))
        else $error("cursor out of range");

    a_scroll_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && scr_reg) |->
            (cur_reg == CW'(CELLS - COLUMNS) && col_reg == '0))
        else $error("scroll did not leave cursor at start of bottom row");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in progress");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=>
            (state_reg == ST_DONE))
        else $error("response loaded over a waiting response");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for text_console_cell_writer: a directed table, then random phases
// under several text colours, scored against a cycle-free screen/cursor predictor,
// unless a table row types its answer. Depends on tccw_pkg and the RTL only.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int SCREEN_COLS    = DEF_COLUMNS;
    localparam int SCREEN_ROWS    = DEF_ROWS;
    localparam int TAB_COLS       = DEF_TAB_STEP;
    localparam int CELLS          = SCREEN_COLS * SCREEN_ROWS;
    localparam int POS_MAX        = (1 << POS_W) - 1;
    localparam int PHASE_ITEMS    = 215;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 25000;

    // operation code the block has no use for
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        tccw_req_t req;
        bit        typed;
        tccw_rsp_t rsp;
    } plan_row_t;

    logic              aclk              = 1'b0;
    logic              aresetn           = 1'b0;
    logic              s_valid           = 1'b0;
    logic              s_ready;
    tccw_req_t         s_req             = '0;
    logic              m_valid;
    logic              m_ready           = 1'b0;
    tccw_rsp_t         m_rsp;
    logic              text_colour_we    = 1'b0;
    logic [CHAR_W-1:0] text_colour_wdata = '0;

    // predictor state
    logic [CELL_W-1:0] screen_model [CELLS];
    int unsigned       cursor_model;
    logic [CHAR_W-1:0] colour_model;

    plan_row_t   row_hints[$];
    tccw_rsp_t   expected_rsp[$];
    int unsigned requests_sent     = 0;
    int unsigned responses_checked = 0;
    int unsigned error_count       = 0;
    int unsigned stall_cycles      = 0;
    bit          quiet             = 1'b0;
    bit          long_hold_pending = 1'b0;

    text_console_cell_writer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req             (s_req),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rsp             (m_rsp),
        .text_colour_we    (text_colour_we),
        .text_colour_wdata (text_colour_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic bit line_feed();
        int unsigned row;
        row = cursor_model / SCREEN_COLS;
        if (row + 1 >= SCREEN_ROWS) begin
            for (int i = 0; i < CELLS - SCREEN_COLS; i++)
                screen_model[i] = screen_model[i + SCREEN_COLS];
            for (int i = CELLS - SCREEN_COLS; i < CELLS; i++)
                screen_model[i] = {colour_model, 8'h00};
            cursor_model = CELLS - SCREEN_COLS;
            return 1'b1;
        end
        cursor_model = (row + 1) * SCREEN_COLS;
        return 1'b0;
    endfunction

    function automatic tccw_rsp_t console_step(tccw_req_t req);
        tccw_rsp_t   rsp;
        int unsigned col;
        int unsigned next_stop;
        int unsigned cell_idx;
        rsp = '0;
        rsp.write_done = req.end_of_write;
        cell_idx = (req.new_position >= CELLS) ? CELLS - 1 : req.new_position;
        case (req.operation)
            OP_PUT: begin
                case (req.char_byte)
                    CH_CR: ;
                    CH_LF: rsp.scrolled = line_feed();
                    CH_TAB: begin
                        col = cursor_model % SCREEN_COLS;
                        next_stop = (col / TAB_COLS + 1) * TAB_COLS;
                        if (next_stop >= SCREEN_COLS)
                            rsp.scrolled = line_feed();
                        else
                            cursor_model = cursor_model - col + next_stop;
                    end
                    CH_BS: begin
                        if (cursor_model != 0) begin
                            cursor_model--;
                            screen_model[cursor_model] = {colour_model, 8'h00};
                        end
                    end
                    default: begin
                        screen_model[cursor_model] = {colour_model, req.char_byte};
                        if ((cursor_model + 1) % SCREEN_COLS == 0)
                            rsp.scrolled = line_feed();
                        else
                            cursor_model++;
                    end
                endcase
            end
            OP_SEEK: cursor_model = cell_idx;
            OP_READ: rsp.cell_data = screen_model[cell_idx];
            default: ;
        endcase
        rsp.cursor_now = cursor_model[POS_W-1:0];
        return rsp;
    endfunction

    // ---------------------------------------------------------------- scoreboard

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        error_count++;
        if (error_count <= 100)
            $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        tccw_rsp_t want;
        plan_row_t hint;
        if (!aresetn) begin
            cursor_model = 0;
            colour_model = COLOUR_RESET;
            for (int i = 0; i < CELLS; i++)
                screen_model[i] = '0;
        end else begin
            if (text_colour_we)
                colour_model = text_colour_wdata;
            if (s_valid && s_ready) begin
                want = console_step(s_req);
                hint = row_hints.pop_front();
                // table rows with a typed-in answer take precedence
                if (hint.typed)
                    want = hint.rsp;
                expected_rsp.push_back(want);
            end
            if (m_valid && m_ready) begin
                responses_checked++;
                if (expected_rsp.size() == 0) begin
                    report_mismatch("unexpected response, cursor", m_rsp.cursor_now, 0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (m_rsp.cursor_now !== want.cursor_now)
                        report_mismatch("cursor_now", m_rsp.cursor_now, want.cursor_now);
                    if (m_rsp.cell_data !== want.cell_data)
                        report_mismatch("cell_data", m_rsp.cell_data, want.cell_data);
                    if (m_rsp.scrolled !== want.scrolled)
                        report_mismatch("scrolled", m_rsp.scrolled, want.scrolled);
                    if (m_rsp.write_done !== want.write_done)
                        report_mismatch("write_done", m_rsp.write_done, want.write_done);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- receiver

    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- sender

    function automatic plan_row_t step_row(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                           logic [POS_W-1:0] pos, logic eow,
                                           bit typed = 1'b0, logic [POS_W-1:0] cur = '0,
                                           logic [CELL_W-1:0] data = '0, logic scr = 1'b0);
        plan_row_t r;
        r.req.operation    = op;
        r.req.char_byte    = ch;
        r.req.new_position = pos;
        r.req.end_of_write = eow;
        r.typed            = typed;
        r.rsp.cursor_now   = cur;
        r.rsp.cell_data    = data;
        r.rsp.scrolled     = scr;
        r.rsp.write_done   = eow;
        return r;
    endfunction

    function automatic plan_row_t random_request();
        plan_row_t   r;
        int unsigned k;
        int unsigned back;
        r.typed = 1'b0;
        r.rsp = '0;
        r.req.operation    = OP_PUT;
        r.req.char_byte    = CHAR_W'($urandom_range(0, 255));
        r.req.new_position = POS_W'($urandom_range(0, POS_MAX));
        r.req.end_of_write = ($urandom_range(0, 4) == 0);
        k = $urandom_range(0, 99);
        if (k < 60) begin
            k = $urandom_range(0, 99);
            if (k >= 94)
                r.req.char_byte = CH_CR;
            else if (k >= 86)
                r.req.char_byte = CH_BS;
            else if (k >= 78)
                r.req.char_byte = CH_TAB;
            else if (k >= 70)
                r.req.char_byte = CH_LF;
        end else if (k < 72) begin
            r.req.operation = OP_SEEK;
            k = $urandom_range(0, 99);
            // lean toward the bottom rows so that scrolling gets exercised
            if (k < 25)
                r.req.new_position = POS_W'($urandom_range(CELLS - 2 * SCREEN_COLS, CELLS - 1));
            else if (k < 65)
                r.req.new_position = POS_W'($urandom_range(0, CELLS - 1));
        end else if (k < 94) begin
            r.req.operation = OP_READ;
            k = $urandom_range(0, 99);
            if (k < 50) begin
                back = $urandom_range(0, (cursor_model < 100) ? cursor_model : 100);
                r.req.new_position = POS_W'(cursor_model - back);
            end else if (k < 85) begin
                r.req.new_position = POS_W'($urandom_range(0, CELLS - 1));
            end else begin
                r.req.new_position = POS_W'($urandom_range(CELLS, POS_MAX));
            end
        end else begin
            r.req.operation = OP_UNUSED;
        end
        return r;
    endfunction

    task automatic offer_request(plan_row_t row);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        row_hints.push_back(row);
        requests_sent++;
        s_valid <= 1'b1;
        s_req   <= row.req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender holds back until every response is in, then lets the block settle
    task automatic drain_responses();
        s_valid <= 1'b0;
        while (responses_checked < requests_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_text_colour(logic [CHAR_W-1:0] colour);
        text_colour_we    <= 1'b1;
        text_colour_wdata <= colour;
        @(posedge aclk);
        text_colour_we    <= 1'b0;
    endtask

    initial begin
        plan_row_t         plan[$];
        logic [CHAR_W-1:0] phase_colour [6];

        // directed table; colour is still at its reset value
        plan.push_back(step_row(OP_READ, 8'h00, 11'd0, 1'b0, 1, 11'd0, 16'h0000));
        plan.push_back(step_row(OP_PUT, CH_BS, 11'd0, 1'b0, 1, 11'd0));
        plan.push_back(step_row(OP_PUT, 8'h41, 11'd0, 1'b0, 1, 11'd1));
        plan.push_back(step_row(OP_READ, 8'h00, 11'd0, 1'b0, 1, 11'd1, 16'h0741));
        plan.push_back(step_row(OP_PUT, 8'hFF, 11'd0, 1'b0, 1, 11'd2));
        plan.push_back(step_row(OP_PUT, 8'h00, 11'd0, 1'b0, 1, 11'd3));
        plan.push_back(step_row(OP_READ, 8'h00, 11'd1, 1'b0, 1, 11'd3, 16'h07FF));
        plan.push_back(step_row(OP_PUT, CH_CR, 11'd0, 1'b0, 1, 11'd3));
        plan.push_back(step_row(OP_PUT, CH_TAB, 11'd0, 1'b0, 1, 11'd8));
        plan.push_back(step_row(OP_PUT, CH_BS, 11'd0, 1'b0, 1, 11'd7));
        plan.push_back(step_row(OP_READ, 8'h00, 11'd7, 1'b0, 1, 11'd7, 16'h0700));
        plan.push_back(step_row(OP_PUT, CH_LF, 11'd0, 1'b1, 1, 11'd80));
        plan.push_back(step_row(OP_SEEK, 8'h00, 11'd2047, 1'b1, 1, 11'd1999));
        plan.push_back(step_row(OP_READ, 8'h00, 11'd2047, 1'b0, 1, 11'd1999, 16'h0000));
        plan.push_back(step_row(OP_UNUSED, 8'hFF, 11'd2047, 1'b1, 1, 11'd1999));
        // printable in the last cell: write, then scroll
        plan.push_back(step_row(OP_PUT, 8'h5A, 11'd0, 1'b1, 1, 11'd1920, 16'h0000, 1'b1));
        plan.push_back(step_row(OP_READ, 8'h00, 11'd1919, 1'b0, 1, 11'd1920, 16'h075A));
        plan.push_back(step_row(OP_READ, 8'h00, 11'd1920, 1'b0, 1, 11'd1920, 16'h0700));
        plan.push_back(step_row(OP_READ, 8'h00, 11'd0, 1'b0));
        plan.push_back(step_row(OP_SEEK, 8'h00, 11'd1995, 1'b0));
        // tab past the end of the bottom row scrolls too
        plan.push_back(step_row(OP_PUT, CH_TAB, 11'd0, 1'b0, 1, 11'd1920, 16'h0000, 1'b1));
        plan.push_back(step_row(OP_SEEK, 8'h00, 11'd1919, 1'b0));
        plan.push_back(step_row(OP_PUT, 8'h71, 11'd0, 1'b0));
        plan.push_back(step_row(OP_PUT, CH_LF, 11'd0, 1'b1));
        plan.push_back(step_row(OP_SEEK, 8'h00, 11'd1024, 1'b1));
        plan.push_back(step_row(OP_READ, 8'h00, 11'd1023, 1'b0));

        phase_colour[0] = 8'h00;
        phase_colour[1] = 8'hFF;
        phase_colour[2] = CHAR_W'($urandom_range(1, 254));
        phase_colour[3] = 8'h5A;
        phase_colour[4] = CHAR_W'($urandom_range(0, 255));
        phase_colour[5] = CHAR_W'($urandom_range(0, 255));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i])
            offer_request(plan[i]);
        drain_responses();

        for (int p = 0; p < 6; p++) begin
            set_text_colour(phase_colour[p]);
            quiet = (p == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // one long receiver stall while requests keep coming
                if (p == 1 && n == 60)
                    long_hold_pending = 1'b1;
                offer_request(random_request());
            end
            drain_responses();
        end

        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
